// File: rtl/core/bcet_pkg.sv
// Shared types and constants for the box collision event tracker.
// Holds the transaction structs, action and event codes, and the sequencer state type.
// No dependencies.
package bcet_pkg;

	localparam int COORD_BITS   = 16;
	localparam int SIZE_BITS    = 15;
	localparam int TAG_BITS     = 8;
	localparam int ID_BITS      = 6;
	localparam int NUM_ENTITIES = 64;
	// corner plus size needs one more bit to stay exact; two are kept
	localparam int EXT_BITS     = COORD_BITS + 2;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CHECK = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_ENTER = 2'd1;
	localparam logic [1:0] EV_STAY  = 2'd2;
	localparam logic [1:0] EV_EXIT  = 2'd3;

	typedef struct packed {
		logic [1:0]                   action;
		logic [ID_BITS-1:0]           entity_id;
		logic [ID_BITS-1:0]           other_id;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] off_x;
		logic signed [COORD_BITS-1:0] off_y;
		logic [SIZE_BITS-1:0]         box_width;
		logic [SIZE_BITS-1:0]         box_height;
		logic [TAG_BITS-1:0]          tag_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                   event_kind;
		logic [ID_BITS-1:0]           pair_first;
		logic [ID_BITS-1:0]           pair_second;
		logic signed [COORD_BITS-1:0] overlap_x;
		logic signed [COORD_BITS-1:0] overlap_y;
		logic [SIZE_BITS-1:0]         overlap_w;
		logic [SIZE_BITS-1:0]         overlap_h;
	} out_item_t;

	// classified command passed from front to back
	typedef struct packed {
		logic [1:0]                   action;
		logic [ID_BITS-1:0]           entity_id;
		logic [ID_BITS-1:0]           other_id;
		logic signed [COORD_BITS-1:0] corner_x;
		logic signed [COORD_BITS-1:0] corner_y;
		logic [SIZE_BITS-1:0]         box_width;
		logic [SIZE_BITS-1:0]         box_height;
		logic [TAG_BITS-1:0]          tag_code;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	typedef enum logic {
		ST_FETCH,
		ST_EXEC
	} back_state_t;

endpackage

// File: rtl/core/box_collision_event_tracker_top.sv
// Box collision event tracker, top level: wires the front end to the back end.
// Each accepted transaction gives exactly one result, in order. The back end
// sequencer has a fetch state, for the registered reads of the box tables and
// the pair status row, and an exec state, to evaluate and write back, which
// waits while the result queue is full; fetch follows exec. A two-entry queue
// sits on each side of the back end, so input is taken while results wait.
// Pair status is clear right after reset through per-row valid bits; no
// clearing pass is needed. Depends on bcet_pkg, bcet_front and bcet_back.
module box_collision_event_tracker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bcet_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output bcet_pkg::out_item_t result
);

	bcet_pkg::cmd_chan_t cmd_chan;
	logic                cmd_pop;

	bcet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_chan (cmd_chan),
		.cmd_pop  (cmd_pop)
	);

	bcet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_chan (cmd_chan),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// File: rtl/core/bcet_front.sv
// Front end: accepts input transactions, forms the saturated box corner,
// and holds classified commands in a two-entry queue for the back end.
// Depends on bcet_pkg.
module bcet_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bcet_pkg::in_item_t  item,
	output bcet_pkg::cmd_chan_t cmd_chan,
	input  logic                cmd_pop
);

	bcet_pkg::cmd_t q_mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;
	bcet_pkg::cmd_t cmd_in;

	function automatic logic signed [bcet_pkg::COORD_BITS-1:0] sat_add(
		input logic signed [bcet_pkg::COORD_BITS-1:0] a,
		input logic signed [bcet_pkg::COORD_BITS-1:0] b
	);
		logic signed [bcet_pkg::COORD_BITS:0]   sum;
		logic signed [bcet_pkg::COORD_BITS-1:0] res;
		sum = {a[bcet_pkg::COORD_BITS-1], a} + {b[bcet_pkg::COORD_BITS-1], b};
		if (sum[bcet_pkg::COORD_BITS] != sum[bcet_pkg::COORD_BITS-1]) begin
			// overflow: clamp toward the sign of the true sum
			res = {sum[bcet_pkg::COORD_BITS], {(bcet_pkg::COORD_BITS-1){~sum[bcet_pkg::COORD_BITS]}}};
		end else begin
			res = sum[bcet_pkg::COORD_BITS-1:0];
		end
		return res;
	endfunction

	always_comb begin
		cmd_in.action     = item.action;
		cmd_in.entity_id  = item.entity_id;
		cmd_in.other_id   = item.other_id;
		cmd_in.corner_x   = sat_add(item.pos_x, item.off_x);
		cmd_in.corner_y   = sat_add(item.pos_y, item.off_y);
		cmd_in.box_width  = item.box_width;
		cmd_in.box_height = item.box_height;
		cmd_in.tag_code   = item.tag_code;
	end

	assign full           = (count_q == 2'd2);
	assign do_push        = push && !full;
	assign do_pop         = cmd_pop && (count_q != 2'd0);
	assign cmd_chan.valid = (count_q != 2'd0);
	assign cmd_chan.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/bcet_back.sv
// Back end: two-step sequencer that reads the box tables and pair status row,
// then evaluates the intersection, writes back state and queues the result.
// Depends on bcet_pkg.
module bcet_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcet_pkg::cmd_chan_t  cmd_chan,
	output logic                 cmd_pop,
	output logic                 empty,
	input  logic                 pop,
	output bcet_pkg::out_item_t  result
);

	localparam int CW = bcet_pkg::COORD_BITS;
	localparam int SW = bcet_pkg::SIZE_BITS;
	localparam int TW = bcet_pkg::TAG_BITS;
	localparam int EW = bcet_pkg::EXT_BITS;
	localparam int NE = bcet_pkg::NUM_ENTITIES;

	bcet_pkg::back_state_t state_q, state_d;

	// box tables, pair status rows and their valid bits
	logic [2*CW-1:0]     corner_mem [NE];
	logic [2*SW+TW-1:0]  size_tag_mem [NE];
	logic [NE-1:0]       pair_mem [NE];
	logic [NE-1:0]       row_valid_q;

	bcet_pkg::cmd_t      cmd_q;
	logic [2*CW-1:0]     corner_a_q, corner_b_q;
	logic [2*SW+TW-1:0]  size_tag_a_q, size_tag_b_q;
	logic [NE-1:0]       pair_row_q;

	bcet_pkg::out_item_t oq_mem [2];
	logic                oq_wr_q, oq_rd_q;
	logic [1:0]          oq_count_q;
	logic                oq_push, oq_pop, oq_full;

	logic                fetch_go;
	logic                exec_go;

	logic signed [EW-1:0] ax, ay, bx, by, ax1, ay1, bx1, by1;
	logic signed [EW-1:0] x0, x1, y0, y1, dx, dy;
	logic [SW-1:0]        aw, ah, bw, bh;
	logic [TW-1:0]        atag, btag;
	logic                 nonempty, hit, was, tag_diff, is_check, is_reset;
	logic                 row_write, row_bit;
	logic [NE-1:0]        row_cur, row_new;
	bcet_pkg::out_item_t  res_d;

	assign oq_full = (oq_count_q == 2'd2);
	assign oq_pop  = pop && (oq_count_q != 2'd0);
	assign empty   = (oq_count_q == 2'd0);
	assign result  = oq_mem[oq_rd_q];

	always_comb begin
		state_d  = state_q;
		fetch_go = 1'b0;
		exec_go  = 1'b0;
		unique case (state_q)
			bcet_pkg::ST_FETCH: begin
				if (cmd_chan.valid) begin
					fetch_go = 1'b1;
					state_d  = bcet_pkg::ST_EXEC;
				end
			end
			bcet_pkg::ST_EXEC: begin
				if (!oq_full) begin
					exec_go = 1'b1;
					state_d = bcet_pkg::ST_FETCH;
				end
			end
			default: state_d = bcet_pkg::ST_FETCH;
		endcase
	end

	assign cmd_pop = fetch_go;
	assign oq_push = exec_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcet_pkg::ST_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	// registered table reads
	always_ff @(posedge clk) begin
		if (fetch_go) begin
			cmd_q        <= cmd_chan.cmd;
			corner_a_q   <= corner_mem[cmd_chan.cmd.entity_id];
			corner_b_q   <= corner_mem[cmd_chan.cmd.other_id];
			size_tag_a_q <= size_tag_mem[cmd_chan.cmd.entity_id];
			size_tag_b_q <= size_tag_mem[cmd_chan.cmd.other_id];
			pair_row_q   <= pair_mem[cmd_chan.cmd.entity_id];
		end
	end

	always_comb begin
		ax = {{2{corner_a_q[2*CW-1]}}, corner_a_q[2*CW-1:CW]};
		ay = {{2{corner_a_q[CW-1]}}, corner_a_q[CW-1:0]};
		bx = {{2{corner_b_q[2*CW-1]}}, corner_b_q[2*CW-1:CW]};
		by = {{2{corner_b_q[CW-1]}}, corner_b_q[CW-1:0]};
		{aw, ah, atag} = size_tag_a_q;
		{bw, bh, btag} = size_tag_b_q;
		ax1 = ax + {{(EW-SW){1'b0}}, aw};
		ay1 = ay + {{(EW-SW){1'b0}}, ah};
		bx1 = bx + {{(EW-SW){1'b0}}, bw};
		by1 = by + {{(EW-SW){1'b0}}, bh};
		x0  = (ax > bx) ? ax : bx;
		y0  = (ay > by) ? ay : by;
		x1  = (ax1 < bx1) ? ax1 : bx1;
		y1  = (ay1 < by1) ? ay1 : by1;
		dx  = x1 - x0;
		dy  = y1 - y0;
		nonempty = (aw != '0) && (ah != '0) && (bw != '0) && (bh != '0);
		hit      = nonempty && (x1 > x0) && (y1 > y0);

		is_check = (cmd_q.action == bcet_pkg::ACT_CHECK);
		is_reset = (cmd_q.action == bcet_pkg::ACT_RESET);
		tag_diff = (atag != btag);
		// a row never written since reset reads as all clear
		row_cur  = row_valid_q[cmd_q.entity_id] ? pair_row_q : '0;
		was      = row_cur[cmd_q.other_id];
		row_bit  = is_check && hit;
		row_write = (is_check && tag_diff) || is_reset;
		row_new  = row_cur;
		row_new[cmd_q.other_id] = row_bit;

		res_d.event_kind  = bcet_pkg::EV_NONE;
		res_d.pair_first  = cmd_q.entity_id;
		res_d.pair_second = cmd_q.other_id;
		res_d.overlap_x   = '0;
		res_d.overlap_y   = '0;
		res_d.overlap_w   = '0;
		res_d.overlap_h   = '0;
		if (is_check && tag_diff) begin
			priority if (hit && !was) begin
				res_d.event_kind = bcet_pkg::EV_ENTER;
			end else if (hit) begin
				res_d.event_kind = bcet_pkg::EV_STAY;
			end else if (was) begin
				res_d.event_kind = bcet_pkg::EV_EXIT;
			end else begin
				res_d.event_kind = bcet_pkg::EV_NONE;
			end
			if (hit) begin
				res_d.overlap_x = x0[CW-1:0];
				res_d.overlap_y = y0[CW-1:0];
				res_d.overlap_w = dx[SW-1:0];
				res_d.overlap_h = dy[SW-1:0];
			end
		end
	end

	// state write-back
	always_ff @(posedge clk) begin
		if (exec_go && cmd_q.action == bcet_pkg::ACT_WRITE) begin
			corner_mem[cmd_q.entity_id]   <= {cmd_q.corner_x, cmd_q.corner_y};
			size_tag_mem[cmd_q.entity_id] <= {cmd_q.box_width, cmd_q.box_height,
				cmd_q.tag_code};
		end
		if (exec_go && row_write) begin
			pair_mem[cmd_q.entity_id] <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (exec_go && row_write) begin
			row_valid_q[cmd_q.entity_id] <= 1'b1;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem[oq_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= 1'b0;
			oq_rd_q    <= 1'b0;
			oq_count_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			unique case ({oq_push, oq_pop})
				2'b10:   oq_count_q <= oq_count_q + 2'd1;
				2'b01:   oq_count_q <= oq_count_q - 2'd1;
				default: oq_count_q <= oq_count_q;
			endcase
		end
	end

endmodule

// File: dv/box_collision_event_tracker_top_tb.sv
// Testbench for the box collision event tracker: directed and random transactions,
// random idling on both queue sides, in-order checking against a scoreboard model.
// Depends on bcet_pkg and box_collision_event_tracker_top.
import bcet_pkg::*;

class collision_scoreboard;
	logic signed [COORD_BITS-1:0] corner_x [NUM_ENTITIES];
	logic signed [COORD_BITS-1:0] corner_y [NUM_ENTITIES];
	logic [SIZE_BITS-1:0]         size_w [NUM_ENTITIES];
	logic [SIZE_BITS-1:0]         size_h [NUM_ENTITIES];
	logic [TAG_BITS-1:0]          tag [NUM_ENTITIES];
	bit                           touching [NUM_ENTITIES*NUM_ENTITIES];
	out_item_t                    pending_events [$];
	int errors;
	int n_writes, n_checks, n_clears, n_enter, n_stay, n_exit;

	function new();
		for (int i = 0; i < NUM_ENTITIES; i++) begin
			corner_x[i] = '0;
			corner_y[i] = '0;
			size_w[i] = '0;
			size_h[i] = '0;
			tag[i] = '0;
		end
		foreach (touching[k])
			touching[k] = 1'b0;
	endfunction

	function logic signed [COORD_BITS-1:0] clamp_coord(int v);
		int hi;
		hi = (1 << (COORD_BITS - 1)) - 1;
		if (v > hi)
			return COORD_BITS'(hi);
		if (v < -hi - 1)
			return COORD_BITS'(-hi - 1);
		return COORD_BITS'(v);
	endfunction

	// works out the event for an accepted transaction and queues it
	function void note_item(in_item_t it);
		out_item_t ev;
		int a, b, k;
		int ax, ay, aw, ah, bx, by, bw, bh;
		int x0, x1, y0, y1;
		bit now, was;
		ev = '0;
		ev.pair_first = it.entity_id;
		ev.pair_second = it.other_id;
		a = int'(it.entity_id);
		b = int'(it.other_id);
		k = a * NUM_ENTITIES + b;
		case (it.action)
			ACT_WRITE: begin
				n_writes++;
				corner_x[a] = clamp_coord(int'(it.pos_x) + int'(it.off_x));
				corner_y[a] = clamp_coord(int'(it.pos_y) + int'(it.off_y));
				size_w[a] = it.box_width;
				size_h[a] = it.box_height;
				tag[a] = it.tag_code;
			end
			ACT_CHECK: begin
				n_checks++;
				if (tag[a] != tag[b]) begin
					ax = int'(corner_x[a]);
					ay = int'(corner_y[a]);
					aw = int'(size_w[a]);
					ah = int'(size_h[a]);
					bx = int'(corner_x[b]);
					by = int'(corner_y[b]);
					bw = int'(size_w[b]);
					bh = int'(size_h[b]);
					x0 = (ax > bx) ? ax : bx;
					x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
					y0 = (ay > by) ? ay : by;
					y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
					// empty boxes and edge-only contact never count
					now = aw > 0 && ah > 0 && bw > 0 && bh > 0 && x1 > x0 && y1 > y0;
					was = touching[k];
					if (now && !was) begin
						ev.event_kind = EV_ENTER;
						n_enter++;
					end else if (now) begin
						ev.event_kind = EV_STAY;
						n_stay++;
					end else if (was) begin
						ev.event_kind = EV_EXIT;
						n_exit++;
					end
					touching[k] = now;
					if (now) begin
						ev.overlap_x = COORD_BITS'(x0);
						ev.overlap_y = COORD_BITS'(y0);
						ev.overlap_w = SIZE_BITS'(x1 - x0);
						ev.overlap_h = SIZE_BITS'(y1 - y0);
					end
				end
			end
			ACT_RESET: begin
				n_clears++;
				touching[k] = 1'b0;
			end
			default: ;
		endcase
		pending_events.push_back(ev);
	endfunction

	function void flag(string field, logic [COORD_BITS-1:0] want_v,
			logic [COORD_BITS-1:0] got_v);
		errors++;
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
	endfunction

	function void check_event(out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			errors++;
			$display("%0t: result %h with no transaction outstanding", $time, got);
			return;
		end
		want = pending_events.pop_front();
		if (got.event_kind !== want.event_kind)
			flag("event_kind", COORD_BITS'(want.event_kind), COORD_BITS'(got.event_kind));
		if (got.pair_first !== want.pair_first)
			flag("pair_first", COORD_BITS'(want.pair_first), COORD_BITS'(got.pair_first));
		if (got.pair_second !== want.pair_second)
			flag("pair_second", COORD_BITS'(want.pair_second),
				COORD_BITS'(got.pair_second));
		if (got.overlap_x !== want.overlap_x)
			flag("overlap_x", want.overlap_x, got.overlap_x);
		if (got.overlap_y !== want.overlap_y)
			flag("overlap_y", want.overlap_y, got.overlap_y);
		if (got.overlap_w !== want.overlap_w)
			flag("overlap_w", COORD_BITS'(want.overlap_w), COORD_BITS'(got.overlap_w));
		if (got.overlap_h !== want.overlap_h)
			flag("overlap_h", COORD_BITS'(want.overlap_h), COORD_BITS'(got.overlap_h));
	endfunction
endclass

module box_collision_event_tracker_top_tb;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	collision_scoreboard board;
	bit   calm = 1'b0;
	bit   known [NUM_ENTITIES];
	logic [ID_BITS-1:0] known_ids [$];

	box_collision_event_tracker_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 25);
	endfunction

	function automatic in_item_t random_item();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic logic [ID_BITS-1:0] pick_known();
		return known_ids[$urandom_range(known_ids.size() - 1)];
	endfunction

	// called at a rising edge; returns at the edge that accepts the transaction
	task automatic send_item(input in_item_t it);
		while (idle_now()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_item(it);
		if (it.action == ACT_WRITE && !known[it.entity_id]) begin
			known[it.entity_id] = 1'b1;
			known_ids.push_back(it.entity_id);
		end
	endtask

	task automatic put_box(input int id, input int px, input int py, input int ox,
			input int oy, input int w, input int h, input int t);
		in_item_t it;
		it = random_item();
		it.action = ACT_WRITE;
		it.entity_id = ID_BITS'(id);
		it.pos_x = COORD_BITS'(px);
		it.pos_y = COORD_BITS'(py);
		it.off_x = COORD_BITS'(ox);
		it.off_y = COORD_BITS'(oy);
		it.box_width = SIZE_BITS'(w);
		it.box_height = SIZE_BITS'(h);
		it.tag_code = TAG_BITS'(t);
		send_item(it);
	endtask

	task automatic put_pair(input logic [1:0] act, input int a, input int b);
		in_item_t it;
		it = random_item();
		it.action = act;
		it.entity_id = ID_BITS'(a);
		it.other_id = ID_BITS'(b);
		send_item(it);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending_events.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		put_box(0, 0, 0, 0, 0, 10, 10, 1);
		put_box(1, 3, 3, 2, 2, 10, 10, 2);
		put_pair(ACT_CHECK, 0, 1);                 // enter
		put_pair(ACT_CHECK, 0, 1);                 // stay
		put_box(1, 10, 0, 0, 0, 10, 10, 2);        // edges touch only
		put_pair(ACT_CHECK, 0, 1);                 // exit
		put_pair(ACT_CHECK, 0, 1);
		put_box(2, 2, 2, 0, 0, 4, 4, 1);           // same tag as entity 0
		put_pair(ACT_CHECK, 0, 2);
		put_pair(ACT_CHECK, 1, 1);
		put_box(1, 5, 5, 0, 0, 10, 10, 2);
		put_pair(ACT_CHECK, 1, 0);                 // reversed pair has its own bit
		put_pair(ACT_RESET, 1, 0);
		put_pair(ACT_CHECK, 1, 0);                 // enter again after clear
		put_box(3, 0, 0, 0, 0, 0, 32767, 3);       // zero width
		put_pair(ACT_CHECK, 3, 0);
		put_box(63, 32767, 32767, 32767, 32767, 32767, 32767, 255);
		put_box(62, -32768, -32768, -32768, -32768, 32767, 32767, 0);
		put_box(60, -20000, -20000, 0, 0, 32767, 32767, 9);
		put_pair(ACT_CHECK, 60, 62);
		put_pair(ACT_CHECK, 62, 63);
		put_box(1, 5, 5, 0, 0, 10, 0, 2);          // zero height while touching
		put_pair(ACT_CHECK, 1, 0);
		put_pair(ACT_UNUSED, 63, 63);
		put_pair(ACT_RESET, 40, 41);               // clear on never-written ids
	endtask

	task automatic run_random(input int count);
		in_item_t it;
		int roll;
		for (int n = 0; n < count; n++) begin
			calm = (n >= 300 && n < 420);
			if (n == 550)
				wait_drained();
			if ($urandom_range(9) == 0) begin
				it = random_item();
				it.action = ACT_UNUSED;
				send_item(it);
			end
			it = random_item();
			roll = $urandom_range(99);
			if (roll < 30) begin
				it.action = ACT_WRITE;
				it.entity_id = ($urandom_range(99) < 70) ? ID_BITS'($urandom_range(7))
					: ID_BITS'($urandom_range(63));
				// mostly small boxes near the origin so pairs keep meeting
				if ($urandom_range(9) != 0) begin
					it.pos_x = COORD_BITS'(int'($urandom_range(128)) - 64);
					it.pos_y = COORD_BITS'(int'($urandom_range(128)) - 64);
					it.off_x = COORD_BITS'(int'($urandom_range(32)) - 16);
					it.off_y = COORD_BITS'(int'($urandom_range(32)) - 16);
					it.box_width = ($urandom_range(19) == 0) ? '0
						: SIZE_BITS'($urandom_range(40, 1));
					it.box_height = ($urandom_range(19) == 0) ? '0
						: SIZE_BITS'($urandom_range(40, 1));
					it.tag_code = ($urandom_range(4) == 0) ? TAG_BITS'($urandom)
						: TAG_BITS'($urandom_range(3));
				end
			end else if (roll < 85) begin
				it.action = ACT_CHECK;
				it.entity_id = pick_known();
				it.other_id = pick_known();
			end else begin
				it.action = ACT_RESET;
				if ($urandom_range(99) < 70) begin
					it.entity_id = pick_known();
					it.other_id = pick_known();
				end
			end
			send_item(it);
		end
		calm = 1'b0;
	endtask

	initial begin
		pop <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_event(result);
			pop <= !idle_now();
		end
	end

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(700);
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d box writes, %0d pair checks and %0d pair clears;",
			board.n_writes, board.n_checks, board.n_clears);
		$display("checks gave %0d enter, %0d stay and %0d exit events.",
			board.n_enter, board.n_stay, board.n_exit);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", board.pending_events.size());
		$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: box_collision_event_tracker_top.f
rtl/core/bcet_pkg.sv
rtl/core/bcet_front.sv
rtl/core/bcet_back.sv
rtl/core/box_collision_event_tracker_top.sv
dv/box_collision_event_tracker_top_tb.sv
